// ----- src/bdl_pkg.sv -----
// Shared types and constants for the bounded double-ended list.
package bdl_pkg;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_ENTRY_WIDTH = 32;
    localparam int REQ_W           = 3;
    localparam int ERR_W           = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_HEAD  = 3'd0,
        REQ_INS_TAIL  = 3'd1,
        REQ_REM_HEAD  = 3'd2,
        REQ_REM_TAIL  = 3'd3,
        REQ_READ_HEAD = 3'd4,
        REQ_READ_TAIL = 3'd5,
        REQ_READ_IDX  = 3'd6
    } req_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2,
        ERR_RANGE = 2'd3
    } err_t;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic wr_en;
        logic rd_en;
    } cell_ctrl_t;

endpackage

// ----- src/bdl_cell.sv -----
// One storage cell of the list: holds one entry, shifts to or from its neighbours.
module bdl_cell #(
    parameter int POS         = 0,
    parameter int IDX_W       = 6,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                   aclk,
    input  bdl_pkg::cell_ctrl_t    ctrl,
    input  logic [IDX_W-1:0]       wr_pos,
    input  logic [IDX_W-1:0]       rd_pos,
    input  logic [ENTRY_WIDTH-1:0] prev_data,
    input  logic [ENTRY_WIDTH-1:0] next_data,
    input  logic [ENTRY_WIDTH-1:0] in_value,
    output logic [ENTRY_WIDTH-1:0] data,
    output logic [ENTRY_WIDTH-1:0] rd_data
);

    logic [ENTRY_WIDTH-1:0] data_reg;
    logic [ENTRY_WIDTH-1:0] data_next;
    logic                   wr_hit;
    logic                   rd_hit;

    assign wr_hit = ctrl.wr_en && (wr_pos == IDX_W'(POS));
    assign rd_hit = ctrl.rd_en && (rd_pos == IDX_W'(POS));

    always_comb begin
        if (ctrl.shift_up) begin
            data_next = prev_data;
        end else if (ctrl.shift_down) begin
            data_next = next_data;
        end else if (wr_hit) begin
            data_next = in_value;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = rd_hit ? data_reg : '0;

endmodule

// ----- src/bounded_double_ended_list.sv -----
// Top level of the bounded double-ended list: control, cell row and result register.
//
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the request type
//   (insert head/tail, remove head/tail, read head/tail/index), s_tdata the
//   entry value and the read index. Every request transaction gives exactly
//   one result transaction on the m_ stream carrying the entry read (zero
//   unless a read succeeds), the count held afterwards and an error code
//   (full, empty or index out of range; a failed request changes nothing).
//   Entries live in a row of CAPACITY cells, head in cell 0: inserting at the
//   head or removing it shifts the whole row by one cell. The result is
//   registered and shown in the cycle after its request; one request is
//   taken per cycle while no result is held up, set by the single output
//   register: a new request is taken while the held result is taken.
//   If the receiver stalls, the result stays in the output register and
//   s_tready drops until it is taken.
//   Reset empties the list and the result register; cell contents are not
//   cleared and are never read before being written.
module bounded_double_ended_list #(
    parameter  int CAPACITY    = bdl_pkg::DEF_CAPACITY,
    parameter  int ENTRY_WIDTH = bdl_pkg::DEF_ENTRY_WIDTH,
    localparam int IDX_W       = $clog2(CAPACITY),
    localparam int CNT_W       = $clog2(CAPACITY + 1),
    localparam int S_DATA_W    = ((ENTRY_WIDTH + IDX_W + 7) / 8) * 8,
    localparam int M_DATA_W    = ((ENTRY_WIDTH + CNT_W + bdl_pkg::ERR_W + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [S_DATA_W-1:0]       s_tdata,  // entry_value, entry_index
    input  logic [bdl_pkg::REQ_W-1:0] s_tuser,  // req_type
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [M_DATA_W-1:0]       m_tdata   // read_value, entry_count, error_code
);

    localparam int RES_W = ENTRY_WIDTH + CNT_W + bdl_pkg::ERR_W;

    logic                     s_fire;
    logic [ENTRY_WIDTH-1:0]   in_value;
    logic [IDX_W-1:0]         in_index;
    bdl_pkg::req_t            req;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     full;
    logic                     empty;

    bdl_pkg::cell_ctrl_t      ctrl;
    bdl_pkg::err_t            err;
    logic [IDX_W-1:0]         wr_pos;
    logic [IDX_W-1:0]         rd_pos;

    logic [ENTRY_WIDTH-1:0]   cell_data [CAPACITY];
    logic [ENTRY_WIDTH-1:0]   cell_rd   [CAPACITY];
    logic [ENTRY_WIDTH-1:0]   rd_bus;

    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic [RES_W-1:0]         m_data_reg;
    logic [RES_W-1:0]         m_data_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign in_value = s_tdata[ENTRY_WIDTH-1:0];
    assign in_index = s_tdata[ENTRY_WIDTH +: IDX_W];
    assign req      = bdl_pkg::req_t'(s_tuser);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    always_comb begin
        ctrl       = '0;
        err        = bdl_pkg::ERR_OK;
        wr_pos     = count_reg[IDX_W-1:0];
        rd_pos     = '0;
        count_next = count_reg;
        unique case (req)
            bdl_pkg::REQ_INS_HEAD: begin
                if (full) begin
                    err = bdl_pkg::ERR_FULL;
                end else begin
                    ctrl.shift_up = 1'b1;
                    count_next    = count_reg + 1'b1;
                end
            end
            bdl_pkg::REQ_INS_TAIL: begin
                if (full) begin
                    err = bdl_pkg::ERR_FULL;
                end else begin
                    ctrl.wr_en = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            bdl_pkg::REQ_REM_HEAD: begin
                if (empty) begin
                    err = bdl_pkg::ERR_EMPTY;
                end else begin
                    ctrl.shift_down = 1'b1;
                    count_next      = count_reg - 1'b1;
                end
            end
            bdl_pkg::REQ_REM_TAIL: begin
                if (empty) begin
                    err = bdl_pkg::ERR_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            bdl_pkg::REQ_READ_HEAD: begin
                if (empty) begin
                    err = bdl_pkg::ERR_RANGE;
                end else begin
                    ctrl.rd_en = 1'b1;
                end
            end
            bdl_pkg::REQ_READ_TAIL: begin
                if (empty) begin
                    err = bdl_pkg::ERR_RANGE;
                end else begin
                    ctrl.rd_en = 1'b1;
                    rd_pos     = IDX_W'(count_reg - 1'b1);
                end
            end
            bdl_pkg::REQ_READ_IDX: begin
                if (CNT_W'(in_index) >= count_reg) begin
                    err = bdl_pkg::ERR_RANGE;
                end else begin
                    ctrl.rd_en = 1'b1;
                    rd_pos     = in_index;
                end
            end
            default: begin
            end
        endcase
        if (!s_fire) begin
            ctrl = '0;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ENTRY_WIDTH-1:0] prev_d;
        logic [ENTRY_WIDTH-1:0] next_d;
        if (i == 0) begin : g_first
            assign prev_d = in_value;
        end else begin : g_prev
            assign prev_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign next_d = cell_data[i];
        end else begin : g_next
            assign next_d = cell_data[i+1];
        end
        bdl_cell #(
            .POS         (i),
            .IDX_W       (IDX_W),
            .ENTRY_WIDTH (ENTRY_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .wr_pos    (wr_pos),
            .rd_pos    (rd_pos),
            .prev_data (prev_d),
            .next_data (next_d),
            .in_value  (in_value),
            .data      (cell_data[i]),
            .rd_data   (cell_rd[i])
        );
    end

    always_comb begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_bus = rd_bus | cell_rd[i];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_fire) begin
            m_valid_next = 1'b1;
            m_data_next  = {err, count_next, rd_bus};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_data_reg);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(count_reg))
        else $error("entry count changed without a request");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_tvalid)
        else $error("accepted request gave no result");

    a_fail_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg[RES_W-1 -: bdl_pkg::ERR_W] != bdl_pkg::ERR_OK)
            |-> (m_data_reg[ENTRY_WIDTH-1:0] == '0))
        else $error("failed request returned entry data");

endmodule

// ----- sim/tb.sv -----
// Testbench for the bounded double-ended list: directed, capacity, random and back-pressure tests.
`timescale 1ns / 100ps

module tb;

    localparam int CAPACITY    = bdl_pkg::DEF_CAPACITY;
    localparam int ENTRY_WIDTH = bdl_pkg::DEF_ENTRY_WIDTH;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int S_DATA_W    = ((ENTRY_WIDTH + IDX_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((ENTRY_WIDTH + CNT_W + bdl_pkg::ERR_W + 7) / 8) * 8;
    localparam int CNT_LSB     = ENTRY_WIDTH;
    localparam int ERR_LSB     = ENTRY_WIDTH + CNT_W;
    localparam int unsigned LONG_STALL_CYCLES = 300;

    // request code with no operation behind it
    localparam logic [bdl_pkg::REQ_W-1:0] REQ_UNUSED = 3'd7;

    typedef struct {
        logic [ENTRY_WIDTH-1:0] read_value;
        logic [CNT_W-1:0]       entry_count;
        bdl_pkg::err_t          error_code;
    } list_result_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [S_DATA_W-1:0]          s_tdata;  // entry_value, entry_index
    logic [bdl_pkg::REQ_W-1:0]    s_tuser;  // req_type
    logic                         m_tvalid;
    logic                         m_tready;
    logic [M_DATA_W-1:0]          m_tdata;  // read_value, entry_count, error_code

    logic [ENTRY_WIDTH-1:0] list_store [CAPACITY];
    logic [IDX_W-1:0]       list_head;
    int unsigned            list_count;
    list_result_t           pending_results [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned stall_requests;
    int unsigned stall_seen        = 0;
    int unsigned stall_cycles_left = 0;
    int unsigned mismatch_count;

    bounded_double_ended_list i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Expected result of one accepted request; updates the list state.
    function automatic void apply_request(input logic [bdl_pkg::REQ_W-1:0] req,
                                          input logic [ENTRY_WIDTH-1:0] value,
                                          input logic [IDX_W-1:0] index);
        list_result_t r;
        logic [IDX_W-1:0] slot;
        r.read_value = '0;
        r.error_code = bdl_pkg::ERR_OK;
        case (req)
            bdl_pkg::REQ_INS_HEAD: begin
                if (list_count >= CAPACITY) begin
                    r.error_code = bdl_pkg::ERR_FULL;
                end else begin
                    list_head = list_head - 1'b1;
                    list_store[list_head] = value;
                    list_count++;
                end
            end
            bdl_pkg::REQ_INS_TAIL: begin
                if (list_count >= CAPACITY) begin
                    r.error_code = bdl_pkg::ERR_FULL;
                end else begin
                    slot = list_head + IDX_W'(list_count);
                    list_store[slot] = value;
                    list_count++;
                end
            end
            bdl_pkg::REQ_REM_HEAD: begin
                if (list_count == 0) begin
                    r.error_code = bdl_pkg::ERR_EMPTY;
                end else begin
                    list_head = list_head + 1'b1;
                    list_count--;
                end
            end
            bdl_pkg::REQ_REM_TAIL: begin
                if (list_count == 0) r.error_code = bdl_pkg::ERR_EMPTY;
                else list_count--;
            end
            bdl_pkg::REQ_READ_HEAD: begin
                if (list_count == 0) r.error_code = bdl_pkg::ERR_RANGE;
                else r.read_value = list_store[list_head];
            end
            bdl_pkg::REQ_READ_TAIL: begin
                if (list_count == 0) begin
                    r.error_code = bdl_pkg::ERR_RANGE;
                end else begin
                    slot = list_head + IDX_W'(list_count - 1);
                    r.read_value = list_store[slot];
                end
            end
            bdl_pkg::REQ_READ_IDX: begin
                if (index >= list_count) begin
                    r.error_code = bdl_pkg::ERR_RANGE;
                end else begin
                    slot = list_head + index;
                    r.read_value = list_store[slot];
                end
            end
            default: ;
        endcase
        r.entry_count = CNT_W'(list_count);
        pending_results.push_back(r);
    endfunction

    task automatic send_request(input logic [bdl_pkg::REQ_W-1:0] req,
                                input logic [ENTRY_WIDTH-1:0] value,
                                input logic [IDX_W-1:0] index);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_DATA_W'({index, value});
        do @(posedge aclk); while (!s_tready);
        apply_request(req, value, index);
    endtask

    // fill_bias: chance in percent that a modifying request is an insert
    task automatic send_random_request(input int unsigned fill_bias);
        int unsigned               pick;
        logic [bdl_pkg::REQ_W-1:0] req;
        logic [IDX_W-1:0]          index;
        pick  = $urandom_range(0, 99);
        index = IDX_W'($urandom_range(0, CAPACITY - 1));
        if (pick < 3) begin
            req = REQ_UNUSED;
        end else if (pick < 40) begin
            case ($urandom_range(0, 2))
                0:       req = bdl_pkg::REQ_READ_HEAD;
                1:       req = bdl_pkg::REQ_READ_TAIL;
                default: req = bdl_pkg::REQ_READ_IDX;
            endcase
            if (list_count > 0 && $urandom_range(0, 4) != 0)
                index = IDX_W'($urandom_range(0, list_count - 1));
        end else if ($urandom_range(0, 99) < fill_bias) begin
            req = $urandom_range(0, 1) ? bdl_pkg::REQ_INS_TAIL : bdl_pkg::REQ_INS_HEAD;
        end else begin
            req = $urandom_range(0, 1) ? bdl_pkg::REQ_REM_TAIL : bdl_pkg::REQ_REM_HEAD;
        end
        send_request(req, $urandom(), index);
    endtask

    task automatic wait_all_results;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed;
        send_request(bdl_pkg::REQ_READ_HEAD, '0, '0);
        send_request(bdl_pkg::REQ_READ_TAIL, '0, '0);
        send_request(bdl_pkg::REQ_READ_IDX, '0, '0);
        send_request(bdl_pkg::REQ_REM_HEAD, '0, '0);
        send_request(bdl_pkg::REQ_REM_TAIL, '0, '0);
        send_request(REQ_UNUSED, '1, '1);
        send_request(bdl_pkg::REQ_INS_TAIL, 32'hFFFF_FFFF, '0);
        send_request(bdl_pkg::REQ_INS_HEAD, 32'h0000_0000, '1);
        send_request(bdl_pkg::REQ_INS_TAIL, 32'hA5A5_A5A5, '0);
        send_request(bdl_pkg::REQ_READ_HEAD, '0, '0);
        send_request(bdl_pkg::REQ_READ_TAIL, '0, '0);
        send_request(bdl_pkg::REQ_READ_IDX, '0, 6'd0);
        send_request(bdl_pkg::REQ_READ_IDX, '0, 6'd1);
        send_request(bdl_pkg::REQ_READ_IDX, '0, 6'd2);
        send_request(bdl_pkg::REQ_READ_IDX, '0, 6'd3);
        send_request(bdl_pkg::REQ_READ_IDX, '0, 6'd63);
        send_request(REQ_UNUSED, '0, '0);
        send_request(bdl_pkg::REQ_REM_TAIL, '0, '0);
        send_request(bdl_pkg::REQ_READ_TAIL, '0, '0);
        send_request(bdl_pkg::REQ_REM_HEAD, '0, '0);
        send_request(bdl_pkg::REQ_READ_HEAD, '0, '0);
        send_request(bdl_pkg::REQ_REM_HEAD, '0, '0);
        send_request(bdl_pkg::REQ_REM_HEAD, '0, '0);
    endtask

    task automatic test_capacity_limits;
        while (list_count < CAPACITY) send_random_request(100);
        send_request(bdl_pkg::REQ_INS_HEAD, $urandom(), '0);
        send_request(bdl_pkg::REQ_INS_TAIL, $urandom(), '0);
        send_request(bdl_pkg::REQ_READ_IDX, '0, 6'd63);
        send_request(bdl_pkg::REQ_READ_IDX, '0, 6'd0);
        send_request(bdl_pkg::REQ_READ_TAIL, '0, '0);
        while (list_count > 0) send_random_request(0);
        send_request(bdl_pkg::REQ_REM_TAIL, '0, '0);
    endtask

    task automatic test_random_mix(input int unsigned n_items);
        int unsigned k;
        int unsigned fill_bias;
        fill_bias = 50;
        for (k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                case ((k / 40) % 3)
                    0:       fill_bias = 85;
                    1:       fill_bias = 15;
                    default: fill_bias = 50;
                endcase
            end
            send_random_request(fill_bias);
        end
    endtask

    task automatic test_backpressure;
        int unsigned k;
        stall_requests++;
        for (k = 0; k < 24; k++) send_random_request(60);
    endtask

    task automatic test_pause_until_drained;
        int unsigned k;
        for (k = 0; k < 12; k++) send_random_request(50);
        wait_all_results();
        for (k = 0; k < 12; k++) send_random_request(50);
    endtask

    always @(negedge aclk) begin
        if (stall_seen != stall_requests) begin
            stall_seen        <= stall_requests;
            stall_cycles_left <= LONG_STALL_CYCLES;
            m_tready          <= 1'b0;
        end else if (stall_cycles_left > 0) begin
            m_tready <= 1'b0;
            stall_cycles_left <= stall_cycles_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing expected", m_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[ENTRY_WIDTH-1:0] !== want.read_value)
                    flag_mismatch("read_value", 32'(m_tdata[ENTRY_WIDTH-1:0]),
                                  32'(want.read_value));
                if (m_tdata[CNT_LSB +: CNT_W] !== want.entry_count)
                    flag_mismatch("entry_count", 32'(m_tdata[CNT_LSB +: CNT_W]),
                                  32'(want.entry_count));
                if (m_tdata[ERR_LSB +: bdl_pkg::ERR_W] !== want.error_code)
                    flag_mismatch("error_code", 32'(m_tdata[ERR_LSB +: bdl_pkg::ERR_W]),
                                  32'(want.error_code));
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        list_head      = '0;
        list_count     = 0;
        stall_requests = 0;
        mismatch_count = 0;
        send_idle_pct  = 29;
        recv_idle_pct  = 61;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_capacity_limits();
        test_random_mix(130);
        send_idle_pct = 61;
        recv_idle_pct = 29;
        test_random_mix(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(130);
        test_backpressure();
        test_pause_until_drained();

        wait_all_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
